// ----- hw/rtl/ifht_pkg.sv -----
// ifht_pkg: shared constants, status codes and cell command types for the
// IPv4 fragment hole tracker. Used by the context cell, the top level and the checker.
package ifht_pkg;

    localparam int CONTEXTS_DEF = 8;
    localparam int HOLES_DEF    = 8;
    localparam logic [15:0] MAX_PACKET = 16'hFFFF;

    localparam logic [7:0] EXPIRE_AGE_RST = 8'd15;
    localparam logic [7:0] SWEEP_INT_RST  = 8'd10;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRE_AGE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_INTERVAL = 8'd1;

    localparam int MF_BIT     = 13;
    localparam int UNIT_SHIFT = 3;

    localparam int IN_W = 144;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_RANGE    = 3'd3,
        ST_OVERLAP  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_SET,
        OP_DEL,
        OP_SPLIT,
        OP_DROP
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic        sweep;
        logic [7:0]  age;
        logic [31:0] now;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] ident;
        logic [15:0] hs;
        logic [15:0] he;
        logic [15:0] ns;
        logic [15:0] ne;
        logic        max_we;
        logic [15:0] max_val;
    } t_cell_cmd;

    // priority chain running along the row of cells
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } t_chain;

    typedef struct packed {
        logic        valid;
        logic        take_hit;
        logic        take_free;
        logic [15:0] e_start;
        logic [15:0] e_end;
        logic [15:0] max_end;
    } t_cell_stat;

endpackage

// ----- hw/rtl/ifht_ctx_cell.sv -----
// ifht_ctx_cell: one reassembly context with its ordered hole list.
// Depends on ifht_pkg; instantiated in a row by ip_fragment_hole_tracker.
module ifht_ctx_cell import ifht_pkg::*; #(
    parameter int HOLES = HOLES_DEF,
    localparam int RW = $clog2(HOLES),
    localparam int CW = $clog2(HOLES + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_sel,
    input  t_cell_cmd      i_cmd,
    input  logic [RW-1:0]  i_rank,
    input  t_chain         i_chain,
    output t_chain         o_chain,
    output t_cell_stat     o_stat,
    output logic [CW-1:0]  o_count
);

    logic          r_valid;
    logic [CW-1:0] r_count;
    logic [31:0]   r_src;
    logic [31:0]   r_dst;
    logic [15:0]   r_ident;
    logic [31:0]   r_created;
    logic [15:0]   r_max_end;
    // holes kept packed in list order: entry k is rank k
    logic [15:0]   r_hs [HOLES];
    logic [15:0]   r_he [HOLES];

    logic          hit;
    logic          expired;

    assign hit = r_valid && r_src == i_cmd.src && r_dst == i_cmd.dst
                 && r_ident == i_cmd.ident;
    assign expired = r_valid && ((i_cmd.now - r_created) > {24'd0, i_cmd.age});

    assign o_chain.hit_seen  = i_chain.hit_seen | hit;
    assign o_chain.free_seen = i_chain.free_seen | ~r_valid;

    assign o_stat.valid     = r_valid;
    assign o_stat.take_hit  = hit & ~i_chain.hit_seen;
    assign o_stat.take_free = ~r_valid & ~i_chain.free_seen;
    assign o_stat.e_start   = r_hs[i_rank];
    assign o_stat.e_end     = r_he[i_rank];
    assign o_stat.max_end   = r_max_end;
    assign o_count          = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cmd.sweep && expired) begin
                r_valid <= 1'b0;
                r_count <= '0;
            end
            if (i_sel) begin
                case (i_cmd.op)
                    OP_INIT: begin
                        r_valid   <= 1'b1;
                        r_count   <= CW'(1);
                        r_src     <= i_cmd.src;
                        r_dst     <= i_cmd.dst;
                        r_ident   <= i_cmd.ident;
                        r_created <= i_cmd.now;
                        r_max_end <= '0;
                        r_hs[0]   <= '0;
                        r_he[0]   <= MAX_PACKET;
                    end
                    OP_SET: begin
                        r_hs[i_rank] <= i_cmd.hs;
                        r_he[i_rank] <= i_cmd.he;
                    end
                    OP_DEL: begin
                        for (int k = 0; k < HOLES - 1; k++) begin
                            if (k >= int'(i_rank)) begin
                                r_hs[k] <= r_hs[k+1];
                                r_he[k] <= r_he[k+1];
                            end
                        end
                        r_count <= r_count - CW'(1);
                    end
                    OP_SPLIT: begin
                        // new right-hand hole goes to the front, rest move down
                        for (int k = 1; k < HOLES; k++) begin
                            r_hs[k] <= r_hs[k-1];
                            r_he[k] <= (k - 1 == int'(i_rank)) ? i_cmd.he : r_he[k-1];
                        end
                        r_hs[0] <= i_cmd.ns;
                        r_he[0] <= i_cmd.ne;
                        r_count <= r_count + CW'(1);
                    end
                    OP_DROP: begin
                        r_valid <= 1'b0;
                        r_count <= '0;
                    end
                    default: ;
                endcase
                if (i_cmd.max_we)
                    r_max_end <= i_cmd.max_val;
            end
        end
    end

endmodule

// ----- hw/rtl/ip_fragment_hole_tracker.sv -----
// ip_fragment_hole_tracker: top level, sequencer over a row of context cells.
// Depends on ifht_pkg and ifht_ctx_cell.
//
//  channel   | direction | handshake                      | content
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | fragment header item
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | one result item per fragment
//  cfg       | in        | i_cfg_valid / o_cfg_ready      | register index and 8-bit data
//
// One item at a time: accept, expiry sweep, context lookup, hole walk, result load.
// The walk visits holes in rank order up to the one filled, or every hole when none is hit;
// an item out of range or finding the context table full skips the walk.
// Synchronous active-low reset clears all contexts.
// A stalled result holds the next item in the result load state until it drains.
module ip_fragment_hole_tracker import ifht_pkg::*; #(
    parameter int CONTEXTS          = CONTEXTS_DEF,
    parameter int HOLES_PER_CONTEXT = HOLES_DEF,
    localparam int SW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1,
    localparam int LW    = $clog2(CONTEXTS + 1),
    localparam int OUT_W = ((36 + SW + LW + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // now_seconds, src_address, dst_address, datagram_ident, offset_word,
    // payload_length
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, context_slot, write_offset, total_length, live_contexts, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int H  = HOLES_PER_CONTEXT;
    localparam int RW = $clog2(H);
    localparam int CW = $clog2(H + 1);

    typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_LOOK, S_WALK, S_DONE} t_state;

    t_state        r_state;
    logic [7:0]    r_expire_age;
    logic [7:0]    r_sweep_int;
    logic [31:0]   r_last_sweep;
    logic [31:0]   r_now, r_src, r_dst;
    logic [15:0]   r_ident, r_off, r_len;
    logic [SW-1:0] r_slot;
    logic [CW-1:0] r_rank;
    t_status       r_res_status;
    logic [15:0]   r_res_woff;
    logic [16:0]   r_res_total;
    logic          r_m_valid;
    logic [OUT_W-1:0] r_m_data;

    t_cell_cmd     cmd;
    t_chain        chain [CONTEXTS+1];
    t_cell_stat    stat  [CONTEXTS];
    logic [CW-1:0] cnt   [CONTEXTS];
    logic [CONTEXTS-1:0] sel;

    logic          found, any_free, due;
    logic [SW-1:0] hit_idx, free_idx;
    logic [LW-1:0] live;
    logic [15:0]   first;
    logic [17:0]   sum18;
    logic [16:0]   sum;
    logic [15:0]   hs, he, max_end, he_t, tf, newmax;
    logic [CW-1:0] c_cnt;
    logic [16:0]   he1, tl, lm1, tlm1;
    logic          trim, miss, ovl, at_start, at_end;
    logic          w_done;
    t_status       w_status;
    logic [15:0]   w_woff;
    logic [16:0]   w_total;
    logic          load_out;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign load_out      = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    assign chain[0] = '0;

    for (genvar i = 0; i < CONTEXTS; i++) begin : g_cell
        ifht_ctx_cell #(.HOLES(H)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sel   (sel[i]),
            .i_cmd   (cmd),
            .i_rank  (r_rank[RW-1:0]),
            .i_chain (chain[i]),
            .o_chain (chain[i+1]),
            .o_stat  (stat[i]),
            .o_count (cnt[i])
        );
    end

    assign found    = chain[CONTEXTS].hit_seen;
    assign any_free = chain[CONTEXTS].free_seen;
    assign due      = (r_now - r_last_sweep) > {24'd0, r_sweep_int};

    assign first = {r_off[12:0], 3'b000};
    assign sum18 = {2'b00, first} + {2'b00, r_len};
    assign sum   = sum18[16:0];

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        live     = '0;
        hs       = '0;
        he       = '0;
        max_end  = '0;
        c_cnt    = '0;
        for (int i = 0; i < CONTEXTS; i++) begin
            if (stat[i].take_hit)
                hit_idx = hit_idx | SW'(unsigned'(i));
            if (stat[i].take_free)
                free_idx = free_idx | SW'(unsigned'(i));
            live = live + LW'(stat[i].valid);
            if (r_slot == SW'(unsigned'(i))) begin
                hs      = stat[i].e_start;
                he      = stat[i].e_end;
                max_end = stat[i].max_end;
                c_cnt   = cnt[i];
            end
        end
    end

    // one step of the hole walk on the entry at r_rank
    always_comb begin
        lm1      = sum - 17'd1;
        trim     = !r_off[MF_BIT] && he == MAX_PACKET && sum > {1'b0, hs};
        he_t     = trim ? lm1[15:0] : he;
        he1      = {1'b0, he_t} + 17'd1;
        miss     = ({1'b0, first} > {1'b0, he_t}) || (sum <= {1'b0, hs});
        tl       = (sum > he1) ? he1 : sum;
        tf       = (first > hs) ? first : hs;
        ovl      = {1'b0, tf} >= tl;
        at_start = tf == hs;
        at_end   = tl == he1;
        tlm1     = tl - 17'd1;
        newmax   = (tlm1[15:0] > max_end) ? tlm1[15:0] : max_end;

        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.age     = r_expire_age;
        cmd.now     = r_now;
        cmd.src     = r_src;
        cmd.dst     = r_dst;
        cmd.ident   = r_ident;
        cmd.hs      = hs;
        cmd.he      = he_t;
        cmd.max_val = newmax;
        w_done      = 1'b0;
        w_status    = ST_STORED;
        w_woff      = '0;
        w_total     = '0;
        sel         = '0;

        case (r_state)
            S_SWEEP: begin
                cmd.sweep = due;
            end
            S_LOOK: begin
                if (!found) begin
                    cmd.op = OP_INIT;
                    for (int i = 0; i < CONTEXTS; i++)
                        sel[i] = stat[i].take_free;
                end
            end
            S_WALK: begin
                for (int i = 0; i < CONTEXTS; i++)
                    sel[i] = (r_slot == SW'(unsigned'(i)));
                if (r_rank >= c_cnt) begin
                    w_done   = 1'b1;
                    w_status = ST_IGNORED;
                end else if (miss) begin
                    cmd.op = OP_SET;
                end else if (ovl) begin
                    cmd.op   = OP_SET;
                    w_done   = 1'b1;
                    w_status = ST_OVERLAP;
                end else begin
                    w_done = 1'b1;
                    w_woff = tf;
                    cmd.max_we = 1'b1;
                    if (at_start && at_end) begin
                        if (c_cnt == CW'(1)) begin
                            // last hole filled: datagram done, context freed
                            cmd.op   = OP_DROP;
                            w_status = ST_COMPLETE;
                            w_total  = {1'b0, newmax} + 17'd1;
                        end else begin
                            cmd.op = OP_DEL;
                        end
                    end else if (at_start) begin
                        cmd.op = OP_SET;
                        cmd.hs = tl[15:0];
                    end else if (!at_end) begin
                        if (c_cnt == CW'(H)) begin
                            cmd.op     = OP_SET;
                            cmd.max_we = 1'b0;
                            w_status   = ST_FULL;
                            w_woff     = '0;
                        end else begin
                            cmd.op = OP_SPLIT;
                            cmd.he = tf - 16'd1;
                            cmd.ns = tl[15:0];
                            cmd.ne = he_t;
                        end
                    end else begin
                        cmd.op = OP_SET;
                        cmd.he = tf - 16'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_m_valid    <= 1'b0;
            r_last_sweep <= '0;
            r_expire_age <= EXPIRE_AGE_RST;
            r_sweep_int  <= SWEEP_INT_RST;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_EXPIRE_AGE)
                    r_expire_age <= i_cfg_data;
                else if (i_cfg_index == REG_SWEEP_INTERVAL)
                    r_sweep_int <= i_cfg_data;
            end
            if (load_out)
                r_m_valid <= 1'b1;
            else if (m_axis_tready)
                r_m_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_now   <= s_axis_tdata[31:0];
                        r_src   <= s_axis_tdata[63:32];
                        r_dst   <= s_axis_tdata[95:64];
                        r_ident <= s_axis_tdata[111:96];
                        r_off   <= s_axis_tdata[127:112];
                        r_len   <= s_axis_tdata[143:128];
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (due)
                        r_last_sweep <= r_now;
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_rank      <= '0;
                    r_res_woff  <= '0;
                    r_res_total <= '0;
                    if (!found && !any_free) begin
                        r_slot       <= '0;
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_slot <= found ? hit_idx : free_idx;
                        if (sum18 > 18'd65536) begin
                            r_res_status <= ST_RANGE;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (w_done) begin
                        r_res_status <= w_status;
                        r_res_woff   <= w_woff;
                        r_res_total  <= w_total;
                        r_state      <= S_DONE;
                    end else begin
                        r_rank <= r_rank + CW'(1);
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_m_data  <= OUT_W'({live, r_res_total, r_res_woff, r_slot,
                                             r_res_status});
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/ifht_checker.sv -----
// ifht_checker: port-level assertions for ip_fragment_hole_tracker, bound to it.
// Depends on ifht_pkg.
module ifht_checker import ifht_pkg::*; #(
    parameter int CONTEXTS          = CONTEXTS_DEF,
    localparam int SW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1,
    localparam int LW    = $clog2(CONTEXTS + 1),
    localparam int OUT_W = ((36 + SW + LW + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_W-1:0]     m_axis_tdata
);

    logic [2:0]    status;
    logic [16:0]   total;
    logic [LW-1:0] live;

    assign status = m_axis_tdata[2:0];
    assign total  = m_axis_tdata[19+SW+16:19+SW];
    assign live   = m_axis_tdata[36+SW+LW-1:36+SW];

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one in progress");

    a_total_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != ST_COMPLETE |-> total == 17'd0)
        else $error("total length set without completion");

    a_complete_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_COMPLETE |-> total != 17'd0)
        else $error("completion with zero length");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> live <= LW'(CONTEXTS))
        else $error("live context count beyond table size");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind ip_fragment_hole_tracker ifht_checker #(
    .CONTEXTS (CONTEXTS)
) u_ifht_checker (.*);

// ----- bench/ip_fragment_hole_tracker_test.sv -----
// Self-checking bench for ip_fragment_hole_tracker: fragment headers in, one status item out.
// Holds its own hole-list tracker; depends on ifht_pkg and the RTL only.
module ip_fragment_hole_tracker_test;
    import ifht_pkg::*;

    localparam int NCTX  = 8;
    localparam int NHOLE = 8;
    localparam int OUTW  = 48;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] plen;
        logic [15:0] offw;
        logic [15:0] ident;
        logic [31:0] dst;
        logic [31:0] src;
        logic [31:0] now;
    } t_frag;

    typedef struct {
        t_status     status;
        logic [2:0]  slot;
        logic [15:0] woff;
        logic [16:0] total;
        logic [3:0]  live;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUTW-1:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    ip_fragment_hole_tracker u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tracker state
    logic [7:0]  age_lim, sweep_gap;
    logic        cv[NCTX];
    logic [31:0] csrc[NCTX], cdst[NCTX], cborn[NCTX];
    logic [15:0] cid[NCTX], cmax[NCTX];
    logic        hv[NCTX*NHOLE];
    logic [15:0] hst[NCTX*NHOLE], hen[NCTX*NHOLE];
    int          hrk[NCTX*NHOLE];
    logic [31:0] swept_at;

    t_verdict pending_q[$];
    int errors = 0;
    int send_idle = 0, recv_stall = 0;
    int hold_cycles = 0;
    longint cycles = 0;
    logic [31:0] clock_s = 32'd100;

    // live key pool for well-formed sequences
    logic [31:0] ksrc[4], kdst[4];
    logic [15:0] kid[4];

    function automatic void drop_ctx(int c);
        cv[c] = 1'b0;
        for (int k = 0; k < NHOLE; k++) hv[c*NHOLE+k] = 1'b0;
    endfunction

    function automatic int holes_in(int b);
        int n;
        n = 0;
        for (int k = 0; k < NHOLE; k++) if (hv[b+k]) n++;
        return n;
    endfunction

    function automatic t_verdict track_fragment(t_frag f);
        t_verdict v;
        int c, b, cnt, e, fr, la, mx, hs, he, fe, live;
        bit hit, mf, ended;
        v = '{ST_FULL, 3'd0, 16'd0, 17'd0, 4'd0};
        ended = 1'b0;
        if (f.now - swept_at > {24'd0, sweep_gap}) begin
            for (int i = 0; i < NCTX; i++)
                if (cv[i] && (f.now - cborn[i] > {24'd0, age_lim})) drop_ctx(i);
            swept_at = f.now;
        end
        hit = 1'b0;
        c = 0;
        for (int i = 0; i < NCTX; i++)
            if (!hit && cv[i] && csrc[i] == f.src && cdst[i] == f.dst && cid[i] == f.ident) begin
                hit = 1'b1;
                c = i;
            end
        if (!hit) begin
            c = NCTX;
            for (int i = NCTX - 1; i >= 0; i--) if (!cv[i]) c = i;
            if (c == NCTX) ended = 1'b1;
            else begin
                drop_ctx(c);
                cv[c] = 1'b1; csrc[c] = f.src; cdst[c] = f.dst; cid[c] = f.ident;
                cborn[c] = f.now; cmax[c] = 16'd0;
                hv[c*NHOLE] = 1'b1; hst[c*NHOLE] = 16'd0;
                hen[c*NHOLE] = MAX_PACKET; hrk[c*NHOLE] = 0;
            end
        end
        if (!ended) begin
            v.slot = c[2:0];
            b = c * NHOLE;
            fr = int'(f.offw[12:0]) * 8;
            mf = f.offw[MF_BIT];
            la = fr + int'(f.plen) - 1;
            if (la > 65535) begin
                v.status = ST_RANGE;
                ended = 1'b1;
            end
        end
        if (!ended) begin
            mx = la;
            v.status = ST_IGNORED;
            cnt = holes_in(b);
            for (int r = 0; r < cnt && !ended; r++) begin
                e = -1;
                for (int k = NHOLE - 1; k >= 0; k--) if (hv[b+k] && hrk[b+k] == r) e = b + k;
                if (e < 0) break;
                if (!mf && hen[e] == MAX_PACKET && mx >= int'(hst[e])) hen[e] = mx[15:0];
                hs = int'(hst[e]);
                he = int'(hen[e]);
                if (fr > he || la < hs) continue;
                ended = 1'b1;
                if (la > he) la = he;
                if (fr < hs) fr = hs;
                if (fr > la) begin
                    v.status = ST_OVERLAP;
                    break;
                end
                if (fr == hs) begin
                    if (la == he) begin
                        hv[e] = 1'b0;
                        for (int k = 0; k < NHOLE; k++)
                            if (hv[b+k] && hrk[b+k] > r) hrk[b+k]--;
                    end else hst[e] = 16'(la + 1);
                end else if (la < he) begin
                    fe = -1;
                    for (int k = NHOLE - 1; k >= 0; k--) if (!hv[b+k]) fe = b + k;
                    if (fe < 0) begin
                        v.status = ST_FULL;
                        break;
                    end
                    hen[e] = 16'(fr - 1);
                    for (int k = 0; k < NHOLE; k++) if (hv[b+k]) hrk[b+k]++;
                    hv[fe] = 1'b1; hst[fe] = 16'(la + 1); hen[fe] = 16'(he); hrk[fe] = 0;
                end else hen[e] = 16'(fr - 1);
                if (la > int'(cmax[c])) cmax[c] = la[15:0];
                v.status = ST_STORED;
                v.woff = fr[15:0];
            end
            if (v.status == ST_STORED && holes_in(b) == 0) begin
                v.status = ST_COMPLETE;
                v.total = {1'b0, cmax[c]} + 17'd1;
                drop_ctx(c);
            end
        end
        live = 0;
        for (int i = 0; i < NCTX; i++) if (cv[i]) live++;
        v.live = live[3:0];
        return v;
    endfunction

    task automatic send_fragment(t_frag f);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        pending_q.push_back(track_fragment(f));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (NHOLE + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_EXPIRE_AGE) age_lim = val;
        else if (idx == REG_SWEEP_INTERVAL) sweep_gap = val;
    endtask

    function automatic t_frag make_frag(int key, int off, bit mf, int len);
        t_frag f;
        f.now = clock_s; f.src = ksrc[key]; f.dst = kdst[key]; f.ident = kid[key];
        f.offw = {2'b00, mf, off[12:0]};
        f.plen = len[15:0];
        return f;
    endfunction

    task automatic test_directed();
        send_fragment(make_frag(0, 0, 1, 16));
        send_fragment(make_frag(0, 4, 1, 8));                  // middle split
        send_fragment(make_frag(0, 4, 1, 8));                  // no hole left there
        send_fragment(make_frag(0, 1, 1, 0));                  // zero length in filled range
        send_fragment(make_frag(0, 8191, 1, 16));              // past max packet
        send_fragment(make_frag(0, 1, 1, 20));                 // truncated overlap
        send_fragment(make_frag(0, 6, 0, 8));                  // last fragment trims
        send_fragment(make_frag(0, 3, 1, 8));                  // closes one hole
        send_fragment(make_frag(1, 8191, 0, 8));               // end at 65535
        send_fragment(make_frag(1, 0, 1, 65535));              // full-length fill
        send_fragment(make_frag(2, 0, 0, 0));                  // last at -1
        send_fragment(make_frag(2, 0, 0, 1));                  // last = 0 trim
        begin
            t_frag f;
            f = '1;
            f.now = clock_s;
            send_fragment(f);
        end
        for (int i = 0; i < 7; i++) begin                      // fill hole table
            send_fragment(make_frag(3, 2 + i * 4, 1, 8));
        end
        for (int i = 0; i < 6; i++) begin                      // fill context table
            t_frag f;
            f = make_frag(3, 1, 1, 8);
            f.ident = 16'(16'hA000 + i);
            send_fragment(f);
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            t_frag f;
            int r;
            r = $urandom_range(99);
            if (r < 3) clock_s = clock_s + $urandom_range(40);
            else if (r < 4) clock_s = $urandom;
            if (r < 75) begin
                f = make_frag($urandom_range(3), $urandom_range(40), $urandom_range(1),
                              8 * $urandom_range(6) + ($urandom_range(9) == 0 ? $urandom_range(7) : 0));
                if ($urandom_range(30) == 0) f.offw[15:14] = 2'($urandom_range(3));
            end else begin
                f = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
                f.now = clock_s;
                if (r < 90) f.plen = 16'($urandom_range(64));
            end
            send_fragment(f);
            if ($urandom_range(60) == 0) begin
                int k;
                k = $urandom_range(3);
                ksrc[k] = $urandom; kdst[k] = $urandom; kid[k] = 16'($urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 12; i++) send_fragment(make_frag(0, i, 1, 8));
        drain_results();
        for (int i = 0; i < 4; i++) send_fragment(make_frag(1, 20 + i, 1, 8));
    endtask

    task automatic test_config_sweep();
        write_reg(REG_EXPIRE_AGE, 8'd0);
        write_reg(REG_SWEEP_INTERVAL, 8'd0);
        write_reg(8'd7, 8'h55);                               // unmapped index
        clock_s = clock_s + 1;
        test_random(40);
        write_reg(REG_EXPIRE_AGE, 8'd255);
        write_reg(REG_SWEEP_INTERVAL, 8'd255);
        test_random(60);
        write_reg(REG_EXPIRE_AGE, 8'd3);
        write_reg(REG_SWEEP_INTERVAL, 8'd1);
    endtask

    // result checker and receiver
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end else begin
                t_verdict x;
                x = pending_q.pop_front();
                if (m_axis_tdata[2:0] != x.status) begin
                    $error("status exp %0d got %0d", x.status, m_axis_tdata[2:0]); errors++;
                end
                if (m_axis_tdata[5:3] != x.slot) begin
                    $error("context_slot exp %0d got %0d", x.slot, m_axis_tdata[5:3]); errors++;
                end
                if (m_axis_tdata[21:6] != x.woff) begin
                    $error("write_offset exp %0d got %0d", x.woff, m_axis_tdata[21:6]); errors++;
                end
                if (m_axis_tdata[38:22] != x.total) begin
                    $error("total_length exp %0d got %0d", x.total, m_axis_tdata[38:22]); errors++;
                end
                if (m_axis_tdata[42:39] != x.live) begin
                    $error("live_contexts exp %0d got %0d", x.live, m_axis_tdata[42:39]); errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        age_lim = EXPIRE_AGE_RST;
        sweep_gap = SWEEP_INT_RST;
        swept_at = '0;
        for (int i = 0; i < NCTX; i++) drop_ctx(i);
        for (int k = 0; k < 4; k++) begin
            ksrc[k] = $urandom; kdst[k] = $urandom; kid[k] = 16'($urandom);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_config_sweep();
        test_random(100);
        send_idle = 65;
        test_random(120);
        send_idle = 0; recv_stall = 65;
        test_random(120);
        send_idle = 14; recv_stall = 14;
        test_random(120);
        drain_results();
        if (errors == 0 && pending_q.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
